// ----- rtl/nps_pkg.sv -----
// Shared types and fixed field widths for the nearest palette color search.
// No dependencies; used by the top level, its port checker, the result checker and the testbench.
package nps_pkg;

	localparam int SIZE_W = 9;   // palette_size register
	localparam int IDXF_W = 8;   // entry_index and best_index fields
	localparam int DISTF_W = 26; // best_distance_sq field

	// request kinds carried on s_axis_tuser
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} nps_state_t;

endpackage

// ----- rtl/nearest_palette_color_search_unit.sv -----
// Nearest palette color search: palette memory, pipelined distance unit and sequencer.
// Depends on nps_pkg.
//
// channel   dir  handshake              payload
// config    in   cfg_we                 cfg_wdata = palette_size
// request   in   s_axis_tvalid/tready   tuser = kind; tdata = entry_index, blue, green, red
// result    out  m_axis_tvalid/tready   tdata = best_index, best_distance_sq
//
// A palette write leaves the block ready. A query reads n entries, n = palette_size
// capped at MAX_COLORS: one palette memory read per cycle feeds a three-stage distance
// pipeline. An empty palette skips the search and goes straight to its final state.
// Reset clears control and sets palette_size to 1; the palette memory is undefined
// until written. A result waits in the output register; the next request is taken
// meanwhile, and a later query holds in its final state until that register is free.
module nearest_palette_color_search_unit
	import nps_pkg::*;
#(
	parameter int MAX_COLORS = 256,
	parameter int CHANNEL_BITS = 12,
	localparam int IN_W = ((IDXF_W + 3 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((IDXF_W + DISTF_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // entry_index, blue, green, red, zero pad
	input  logic              s_axis_tuser,  // kind
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata   // best_index, best_distance_sq, zero pad
);

	localparam int CB = CHANNEL_BITS;
	localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int SQ_W = 2 * CB;
	localparam int DW = 2 * CB + 2;

	nps_state_t state_q;

	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  last_q;
	logic [CB-1:0]     qb_q, qg_q, qr_q;

	logic [3*CB-1:0]   mem [MAX_COLORS];

	// request fields
	logic [IDXF_W-1:0] in_index;
	logic [CB-1:0]     in_b, in_g, in_r;
	logic              accept, wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [31:0]       n_sat;

	// distance pipeline
	logic              v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3;
	logic [3*CB-1:0]   rd_data_s1;
	logic [CB-1:0]     db_s2, dg_s2, dr_s2;
	logic [SQ_W-1:0]   sb_s3, sg_s3, sr_s3;
	logic [DW-1:0]     dist_sum;

	logic [IDX_W-1:0]  best_i_q;
	logic [DW-1:0]     best_d_q;

	logic              out_load, out_free;
	logic              m_valid_q;
	logic [IDXF_W-1:0] m_index_q;
	logic [DISTF_W-1:0] m_dist_q;

	assign in_index = s_axis_tdata[IDXF_W-1:0];
	assign in_b = s_axis_tdata[IDXF_W +: CB];
	assign in_g = s_axis_tdata[IDXF_W + CB +: CB];
	assign in_r = s_axis_tdata[IDXF_W + 2 * CB +: CB];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign wr_en = accept && (s_axis_tuser == KIND_WRITE)
		&& (32'(in_index) < 32'(MAX_COLORS));
	assign wr_addr = IDX_W'(in_index);
	assign rd_en = (state_q == ST_SEARCH);
	assign n_sat = (32'(size_q) > 32'(MAX_COLORS)) ? 32'(MAX_COLORS) : 32'(size_q);

	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// palette memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_r, in_g, in_b};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_axis_tuser == KIND_QUERY)) begin
						state_q <= (n_sat == 32'd0) ? ST_FINISH : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (rd_idx_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query registers and read address
	always_ff @(posedge clk) begin
		if (accept && (s_axis_tuser == KIND_QUERY)) begin
			qb_q <= in_b;
			qg_q <= in_g;
			qr_q <= in_r;
			rd_idx_q <= '0;
			last_q <= IDX_W'(n_sat - 32'd1);
		end else if (rd_en) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		db_s2 <= (qb_q >= rd_data_s1[0 +: CB]) ? qb_q - rd_data_s1[0 +: CB]
			: rd_data_s1[0 +: CB] - qb_q;
		dg_s2 <= (qg_q >= rd_data_s1[CB +: CB]) ? qg_q - rd_data_s1[CB +: CB]
			: rd_data_s1[CB +: CB] - qg_q;
		dr_s2 <= (qr_q >= rd_data_s1[2 * CB +: CB]) ? qr_q - rd_data_s1[2 * CB +: CB]
			: rd_data_s1[2 * CB +: CB] - qr_q;
		sb_s3 <= SQ_W'(db_s2) * SQ_W'(db_s2);
		sg_s3 <= SQ_W'(dg_s2) * SQ_W'(dg_s2);
		sr_s3 <= SQ_W'(dr_s2) * SQ_W'(dr_s2);
	end

	assign dist_sum = DW'(sb_s3) + DW'(sg_s3) + DW'(sr_s3);

	// running best: entry zero seeds it, later ones replace only when strictly closer
	always_ff @(posedge clk) begin
		if (accept && (s_axis_tuser == KIND_QUERY)) begin
			best_i_q <= '0;
			best_d_q <= '0;
		end else if (v_s3 && ((idx_s3 == '0) || (dist_sum < best_d_q))) begin
			best_i_q <= idx_s3;
			best_d_q <= dist_sum;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_index_q <= IDXF_W'(best_i_q);
			m_dist_q <= DISTF_W'(best_d_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = OUT_W'({m_dist_q, m_index_q});

endmodule

// ----- rtl/nps_checker.sv -----
// Port-level checker for nearest_palette_color_search_unit, with its bind statement.
// Depends on nps_pkg.
module nps_checker
	import nps_pkg::*;
#(
	parameter int OUT_W = 40
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              s_axis_tuser,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_W-1:0]  m_axis_tdata
);

	// a query request keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY) |=> !s_axis_tready)
		else $error("ready after query request");

	// a palette write leaves the block ready
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_WRITE) |=> s_axis_tready)
		else $error("busy after palette write");

	// a result only appears while a query is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without query");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind nearest_palette_color_search_unit nps_checker #(
	.OUT_W(OUT_W)
) u_nps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

// ----- verif/nps_result_checker.sv -----
// Result checker for the nearest palette color search unit: tracks palette writes and
// size updates, predicts each query's nearest entry and compares the returned results.
// Depends on nps_pkg.
module nps_result_checker
	import nps_pkg::*;
#(
	parameter int MAX_COLORS = 256,
	parameter int CHANNEL_BITS = 12,
	parameter int IN_W = 48,
	parameter int OUT_W = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,
	input  logic              s_axis_tuser,
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [OUT_W-1:0]  m_axis_tdata,
	output int                mismatches,
	output int                outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef logic [2:0][CHANNEL_BITS-1:0] color_t; // [0] blue, [1] green, [2] red

	// index sits in the low bits, as on m_axis_tdata
	typedef struct packed {
		logic [DISTF_W-1:0] dist_sq;
		logic [IDXF_W-1:0]  index;
	} match_t;

	color_t            palette [MAX_COLORS];
	logic [SIZE_W-1:0] searched_size;
	match_t            nearest_q [$];
	int                errors = 0;

	// Scan entries in order; only a strictly smaller distance takes over.
	function automatic match_t nearest_match(input color_t query);
		match_t m;
		longint unsigned best, sum, d;
		int n;
		m = '0;
		best = 0;
		n = (searched_size > MAX_COLORS) ? MAX_COLORS : int'(searched_size);
		for (int i = 0; i < n; i++) begin
			sum = 0;
			for (int k = 0; k < 3; k++) begin
				d = (query[k] >= palette[i][k]) ? query[k] - palette[i][k]
					: palette[i][k] - query[k];
				sum += d * d;
			end
			if (i == 0 || sum < best) begin
				best = sum;
				m.index = IDXF_W'(i);
			end
		end
		m.dist_sq = best[DISTF_W-1:0];
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		match_t got, want;
		if (!arst_n) begin
			searched_size = SIZE_W'(1);
			nearest_q.delete();
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			// check the result first: a request taken at this edge cannot answer yet
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[IDXF_W+DISTF_W-1:0];
				if (nearest_q.size() == 0) begin
					errors++;
					if (errors <= REPORT_LIMIT)
						$display("%0t: result with no query pending: index %0d distance %0d",
							$realtime, got.index, got.dist_sq);
				end else begin
					want = nearest_q.pop_front();
					if (got.index !== want.index || got.dist_sq !== want.dist_sq) begin
						errors++;
						if (errors <= REPORT_LIMIT)
							$display("%0t: nearest mismatch: index exp %0d got %0d, distance exp %0d got %0d",
								$realtime, want.index, got.index, want.dist_sq, got.dist_sq);
					end
				end
			end
			if (cfg_we)
				searched_size = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == KIND_QUERY)
					nearest_q.push_back(nearest_match(s_axis_tdata[IDXF_W +: 3*CHANNEL_BITS]));
				else if (s_axis_tdata[IDXF_W-1:0] < MAX_COLORS)
					palette[s_axis_tdata[IDXF_W-1:0]] = s_axis_tdata[IDXF_W +: 3*CHANNEL_BITS];
			end
			outstanding <= nearest_q.size();
			mismatches <= errors;
		end
	end

endmodule

// ----- verif/nearest_palette_color_search_unit_test.sv -----
// Testbench top for the nearest palette color search unit: drives palette writes, queries
// and size updates with random gaps and stalls; nps_result_checker judges the results.
// Depends on nps_pkg, nearest_palette_color_search_unit and nps_result_checker.
module nearest_palette_color_search_unit_test
	import nps_pkg::*;
;

	localparam int MAX_COLORS = 256;
	localparam int CHANNEL_BITS = 12;
	localparam int IN_W = ((IDXF_W + 3 * CHANNEL_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((IDXF_W + DISTF_W + 7) / 8) * 8;
	localparam int ITEM_TARGET = 1650;
	localparam int SETTLE_CYCLES = 12;
	localparam int LONG_HOLD = 500;
	localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;
	localparam logic [CHANNEL_BITS-1:0] CH_MID = CHANNEL_BITS'(1) << (CHANNEL_BITS - 1);

	typedef logic [2:0][CHANNEL_BITS-1:0] color_t; // [0] blue, [1] green, [2] red

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;  // entry_index, blue, green, red, zero pad
	logic              s_axis_tuser;  // kind
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;  // best_index, best_distance_sq, zero pad
	logic              hold_outputs;

	int     mismatches;
	int     outstanding;
	int     issued = 0;
	int     cur_size = 1;
	bit     written [MAX_COLORS];
	color_t shadow [MAX_COLORS];

	nearest_palette_color_search_unit #(
		.MAX_COLORS(MAX_COLORS),
		.CHANNEL_BITS(CHANNEL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	nps_result_checker #(
		.MAX_COLORS(MAX_COLORS),
		.CHANNEL_BITS(CHANNEL_BITS),
		.IN_W(IN_W),
		.OUT_W(OUT_W)
	) results_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Colors that hit the interesting spots: channel extremes, copies of live entries
	// (ties), small offsets around them (exact and near hits), or anything.
	function automatic color_t shaped_color(input bit nudge);
		color_t c;
		int n, src, v;
		n = (cur_size > MAX_COLORS) ? MAX_COLORS : cur_size;
		for (int k = 0; k < 3; k++)
			c[k] = CHANNEL_BITS'($urandom_range(0, CH_MAX));
		case ($urandom_range(0, 9))
			0, 1: begin
				for (int k = 0; k < 3; k++)
					case ($urandom_range(0, 2))
						0: c[k] = '0;
						1: c[k] = CH_MAX;
						default: c[k] = CH_MID;
					endcase
			end
			2, 3, 4, 5: begin
				src = (n > 0) ? $urandom_range(0, n - 1) : 0;
				if (written[src]) begin
					c = shadow[src];
					if (nudge)
						for (int k = 0; k < 3; k++) begin
							v = int'(c[k]) + int'($urandom_range(0, 6)) - 3;
							if (v < 0)
								v = 0;
							if (v > int'(CH_MAX))
								v = int'(CH_MAX);
							c[k] = v[CHANNEL_BITS-1:0];
						end
				end
			end
			default: ;
		endcase
		return c;
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	task automatic send_request(input logic kind, input logic [IDXF_W-1:0] slot,
		input color_t c);
		logic [IN_W-1:0] word;
		int gap;
		word = '0;
		word[IDXF_W-1:0] = slot;
		word[IDXF_W +: 3*CHANNEL_BITS] = c;
		gap = (((issued / 64) % 5) == 3) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		s_axis_tuser <= kind;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		issued++;
		if (kind == KIND_WRITE) begin
			shadow[slot] = c;
			written[slot] = 1'b1;
		end
	endtask

	// Stop offering and wait until every query has answered and the block is quiet.
	task automatic drain_requests();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_palette_size(input int value);
		drain_requests();
		cfg_we <= 1'b1;
		cfg_wdata <= value[SIZE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_size = value;
	endtask

	initial begin : stimulus
		int sz, n, items;
		logic [IDXF_W-1:0] slot;
		bit pressed;
		pressed = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= KIND_WRITE;
		hold_outputs <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single entry after reset: largest and zero distance
		send_request(KIND_WRITE, 8'd0, '0);
		send_request(KIND_QUERY, 8'd0, '1);
		send_request(KIND_QUERY, 8'd255, '0);
		send_request(KIND_QUERY, 8'd0, {CH_MAX, 12'd0, CH_MAX});
		// two equal entries: the lower index wins the tie
		send_request(KIND_WRITE, 8'd0, '1);
		send_request(KIND_WRITE, 8'd1, '1);
		send_request(KIND_WRITE, 8'd255, {12'hF0F, 12'h555, 12'hAAA});
		write_palette_size(2);
		send_request(KIND_QUERY, 8'd0, '1);
		send_request(KIND_QUERY, 8'd255, '0);
		send_request(KIND_WRITE, 8'd1, '0);
		send_request(KIND_QUERY, 8'd170, color_t'(1));
		// empty palette answers index 0, distance 0
		write_palette_size(0);
		send_request(KIND_QUERY, 8'd85, {12'd789, 12'd456, 12'd123});
		send_request(KIND_QUERY, 8'd0, '1);

		for (int phase = 0; issued < ITEM_TARGET; phase++) begin
			case (phase)
				0: sz = MAX_COLORS;
				1: sz = 0;
				2: sz = (1 << SIZE_W) - 1;
				3: sz = MAX_COLORS - 1;
				4: sz = 1;
				default: sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_COLORS)
					: $urandom_range(1, 12);
			endcase
			write_palette_size(sz);
			n = (sz > MAX_COLORS) ? MAX_COLORS : sz;
			// fill every searched slot before the first query of the phase
			for (int i = 0; i < n; i++)
				if (!written[i])
					send_request(KIND_WRITE, IDXF_W'(i), shaped_color(1'b0));
			items = $urandom_range(20, 60);
			for (int k = 0; k < items; k++) begin
				if (!pressed && issued >= 600 && k == 2) begin
					hold_outputs <= 1'b1;
					pressed = 1'b1;
				end
				if ($urandom_range(0, 4) == 0) begin
					slot = (n > 0 && $urandom_range(0, 2) != 0)
						? IDXF_W'($urandom_range(0, n - 1))
						: IDXF_W'($urandom_range(0, MAX_COLORS - 1));
					send_request(KIND_WRITE, slot, shaped_color(1'b0));
				end else begin
					send_request(KIND_QUERY, IDXF_W'($urandom_range(0, MAX_COLORS - 1)),
						shaped_color(1'b1));
				end
			end
		end

		drain_requests();
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result side: random stall after each result, quiet stretches, one long hold.
	initial begin : result_sink
		int wait_cycles, taken;
		bit held;
		wait_cycles = 0;
		taken = 0;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_outputs && !held) begin
				held = 1'b1;
				wait_cycles = LONG_HOLD;
				m_axis_tready <= 1'b0;
			end else if (m_axis_tvalid && m_axis_tready) begin
				taken++;
				wait_cycles = (((taken / 40) % 5) == 2) ? 0 : $urandom_range(0, 12);
				m_axis_tready <= (wait_cycles == 0);
			end else if (wait_cycles > 0) begin
				wait_cycles--;
				m_axis_tready <= (wait_cycles == 0);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

endmodule
